@@ hdl/pqa_pkg.sv @@
// Shared types, codes and scoring functions for the three-level aging queue.
// Used by pqa_cell and three_level_priority_queue_aging_core.
`default_nettype none
package pqa_pkg;

	localparam int DEF_CAPACITY = 16;
	localparam logic [11:0] THR_RESET = 12'd30;
	localparam logic [9:0] WAIT_MAX = 10'h3FF;

	typedef enum logic [1:0] {
		OP_ENQ  = 2'd0,
		OP_DEQ  = 2'd1,
		OP_PEEK = 2'd2,
		OP_AGE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		LVL_HIGH = 2'd0,
		LVL_MED  = 2'd1,
		LVL_LOW  = 2'd2,
		LVL_NONE = 2'd3
	} lvl_t;

	typedef enum logic [2:0] {
		CLS_WITHDRAW = 3'd0,
		CLS_DEPOSIT  = 3'd1,
		CLS_LOAN     = 3'd2,
		CLS_EMERG    = 3'd3,
		CLS_VIP      = 3'd4
	} cls_t;

	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_INSERT,
		CMD_SHIFT,
		CMD_AGE,
		CMD_SORT
	} cmd_code_t;

	typedef enum logic {
		ST_IDLE,
		ST_SORT
	} state_t;

	typedef struct packed {
		logic        valid;
		lvl_t        lvl;
		logic [15:0] id;
		logic [2:0]  stype;
		logic        emerg;
		logic [9:0]  wait_min;
	} entry_t;

	typedef struct packed {
		cmd_code_t   code;
		logic        parity;
		entry_t      new_ent;
		logic [9:0]  minutes;
		logic [11:0] threshold;
	} cmd_t;

	function automatic logic [11:0] score_of(logic [2:0] stype, logic emerg,
		logic [9:0] wait_min);
		logic [11:0] pts;
		case (stype)
			CLS_WITHDRAW: pts = 12'd10;
			CLS_DEPOSIT:  pts = 12'd15;
			CLS_LOAN:     pts = 12'd20;
			CLS_EMERG:    pts = 12'd30;
			CLS_VIP:      pts = 12'd60;
			default:      pts = 12'd0;
		endcase
		return pts + {1'b0, wait_min, 1'b0} + (emerg ? 12'd50 : 12'd0);
	endfunction

	function automatic lvl_t level_of(logic [2:0] stype, logic emerg,
		logic [9:0] wait_min, logic [11:0] threshold);
		lvl_t l;
		if (stype == CLS_EMERG || stype == CLS_VIP || emerg)
			l = LVL_HIGH;
		else if (stype == CLS_DEPOSIT || stype == CLS_LOAN ||
			score_of(stype, emerg, wait_min) >= threshold)
			l = LVL_MED;
		else
			l = LVL_LOW;
		return l;
	endfunction

	function automatic logic [3:0] svc_minutes(logic [2:0] stype);
		logic [3:0] m;
		case (stype)
			CLS_WITHDRAW: m = 4'd2;
			CLS_DEPOSIT:  m = 4'd5;
			CLS_LOAN:     m = 4'd10;
			CLS_EMERG:    m = 4'd3;
			CLS_VIP:      m = 4'd3;
			default:      m = 4'd5;
		endcase
		return m;
	endfunction

	function automatic logic [1:0] key_of(entry_t e);
		return e.valid ? e.lvl : LVL_NONE;
	endfunction

endpackage
`default_nettype wire

@@ hdl/pqa_cell.sv @@
// One queue cell: holds one entry, in service order, and trades it with its neighbors.
// Depends on pqa_pkg.
`default_nettype none
module pqa_cell import pqa_pkg::*; #(
	parameter int IDX   = 0,
	parameter int CELLS = DEF_CAPACITY
) (
	input  wire    clk,
	input  wire    arst_n,
	input  cmd_t   cmd,
	input  entry_t left_ent,
	input  entry_t right_ent,
	input  logic   left_after,
	output logic   after,
	output entry_t ent
);

	localparam logic IDX_ODD   = 1'((IDX % 2) == 1);
	localparam logic HAS_LEFT  = 1'(IDX > 0);
	localparam logic HAS_RIGHT = 1'(IDX < CELLS - 1);

	entry_t ent_q, ent_d;
	logic [10:0] wsum;
	logic [9:0] wnew;

	assign after = !ent_q.valid || (ent_q.lvl > cmd.new_ent.lvl);
	assign ent = ent_q;

	always_comb begin
		ent_d = ent_q;
		wsum = {1'b0, ent_q.wait_min} + {1'b0, cmd.minutes};
		wnew = wsum[10] ? WAIT_MAX : wsum[9:0];
		case (cmd.code)
			CMD_INSERT: begin
				if (left_after) ent_d = left_ent;
				else if (after) ent_d = cmd.new_ent;
			end
			CMD_SHIFT: ent_d = right_ent;
			CMD_AGE: begin
				ent_d.wait_min = wnew;
				ent_d.lvl = level_of(ent_q.stype, ent_q.emerg, wnew, cmd.threshold);
			end
			CMD_SORT: begin
				if (IDX_ODD == cmd.parity) begin
					if (HAS_RIGHT && key_of(ent_q) > key_of(right_ent)) ent_d = right_ent;
				end else begin
					if (HAS_LEFT && key_of(left_ent) > key_of(ent_q)) ent_d = left_ent;
				end
			end
			default: ent_d = ent_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else begin
			ent_q <= ent_d;
		end
	end

endmodule
`default_nettype wire

@@ hdl/three_level_priority_queue_aging_core.sv @@
// Top level of the three-level aging priority queue: cell row, sequencer, output register.
// Depends on pqa_pkg and pqa_cell.
//
// Entries sit in a row of CAPACITY cells in service order: high, then medium, then low,
// each level first-in first-out. Enqueue, dequeue and peek give their result in the
// output register in the cycle after acceptance. Age updates every cell together, then
// reorders the row by level with an odd-even transposition pass, during which in_stall
// holds off the next transaction. Its result is delivered right away.
`default_nettype none
module three_level_priority_queue_aging_core import pqa_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_wr_en,
	input  wire  [11:0] cfg_wr_data,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [1:0]  operation,
	input  wire  [15:0] id,
	input  wire  [2:0]  service_type,
	input  wire         emergency,
	input  wire  [9:0]  waiting_time,
	input  wire  [9:0]  minutes,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [1:0]  status,
	output logic [15:0] out_id,
	output logic [2:0]  out_service_type,
	output logic        out_emergency,
	output logic [9:0]  out_waiting_time,
	output logic [11:0] priority_score,
	output logic [3:0]  service_minutes,
	output logic [1:0]  level,
	output logic [4:0]  count
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = $clog2(CAPACITY);

	state_t state_q, state_d;
	logic [PW-1:0] phase_q, phase_d;
	logic [CW-1:0] count_q, count_d;
	logic [11:0] thr_q;
	logic accept, full;
	cmd_t cmd;
	entry_t head;
	entry_t ents [CAPACITY];
	logic afters [CAPACITY];

	logic out_valid_q;
	logic [1:0] status_q, level_q;
	logic [15:0] id_q;
	logic [2:0] stype_q;
	logic emerg_q;
	logic [9:0] wait_q;
	logic [11:0] score_q;
	logic [3:0] svc_q;
	logic [CW-1:0] cnt_out_q;

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			entry_t l_ent, r_ent;
			logic l_after;
			if (g == 0) begin : g_first
				assign l_ent = '0;
				assign l_after = 1'b0;
			end else begin : g_mid
				assign l_ent = ents[g-1];
				assign l_after = afters[g-1];
			end
			if (g == CAPACITY - 1) begin : g_last
				assign r_ent = '0;
			end else begin : g_nlast
				assign r_ent = ents[g+1];
			end
			pqa_cell #(.IDX(g), .CELLS(CAPACITY)) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.cmd(cmd),
				.left_ent(l_ent),
				.right_ent(r_ent),
				.left_after(l_after),
				.after(afters[g]),
				.ent(ents[g])
			);
		end
	endgenerate

	assign head = ents[0];
	assign full = (count_q == CW'(CAPACITY));
	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign accept = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		count_d = count_q;
		cmd.code = CMD_HOLD;
		cmd.parity = phase_q[0];
		cmd.minutes = minutes;
		cmd.threshold = thr_q;
		cmd.new_ent.valid = 1'b1;
		cmd.new_ent.lvl = level_of(service_type, emergency, waiting_time, thr_q);
		cmd.new_ent.id = id;
		cmd.new_ent.stype = service_type;
		cmd.new_ent.emerg = emergency;
		cmd.new_ent.wait_min = waiting_time;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (op_t'(operation))
						OP_ENQ: begin
							if (!full) begin
								cmd.code = CMD_INSERT;
								count_d = count_q + 1'b1;
							end
						end
						OP_DEQ: begin
							if (head.valid) begin
								cmd.code = CMD_SHIFT;
								count_d = count_q - 1'b1;
							end
						end
						OP_PEEK: cmd.code = CMD_HOLD;
						OP_AGE: begin
							cmd.code = CMD_AGE;
							state_d = ST_SORT;
							phase_d = '0;
						end
						default: cmd.code = CMD_HOLD;
					endcase
				end
			end
			ST_SORT: begin
				cmd.code = CMD_SORT;
				phase_d = phase_q + 1'b1;
				if (phase_q == PW'(CAPACITY - 1)) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= '0;
			count_q <= '0;
			thr_q <= THR_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			count_q <= count_d;
			if (cfg_wr_en) thr_q <= cfg_wr_data;
			if (accept) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= STAT_OK;
			id_q <= '0;
			stype_q <= '0;
			emerg_q <= 1'b0;
			wait_q <= '0;
			score_q <= '0;
			svc_q <= '0;
			level_q <= '0;
			cnt_out_q <= count_d;
			case (op_t'(operation))
				OP_ENQ: begin
					if (full) status_q <= STAT_FULL;
				end
				OP_DEQ, OP_PEEK: begin
					if (!head.valid) begin
						status_q <= STAT_EMPTY;
					end else begin
						id_q <= head.id;
						stype_q <= head.stype;
						emerg_q <= head.emerg;
						wait_q <= head.wait_min;
						score_q <= score_of(head.stype, head.emerg, head.wait_min);
						svc_q <= svc_minutes(head.stype);
						level_q <= head.lvl;
					end
				end
				default: status_q <= STAT_OK;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign out_id = id_q;
	assign out_service_type = stype_q;
	assign out_emergency = emerg_q;
	assign out_waiting_time = wait_q;
	assign priority_score = score_q;
	assign service_minutes = svc_q;
	assign level = level_q;
	assign count = 5'(cnt_out_q);

endmodule
`default_nettype wire
